/* sv/texture_swizzle_address_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the texture swizzle address generator
// Each macro expects clk and arst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef TEXTURE_SWIZZLE_ADDRESS_DEFINES_SVH
`define TEXTURE_SWIZZLE_ADDRESS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TSA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tsa_pkg.sv */
// ---------------------------------------------------------------------------
// tsa_pkg
// Shared widths, register indexes and helper functions of the texture
// swizzle address generator.
// ---------------------------------------------------------------------------
package tsa_pkg;

	// Field widths
	localparam int unsigned COORD_X_W  = 12;
	localparam int unsigned COORD_Y_W  = 12;
	localparam int unsigned COORD_Z_W  = 9;
	localparam int unsigned LIN_W      = 41;
	localparam int unsigned SWZ_W      = 37;

	// Configuration register widths
	localparam int unsigned SIZE_XY_W  = 13;
	localparam int unsigned SIZE_Z_W   = 10;
	localparam int unsigned PIX_W      = 5;
	localparam int unsigned ROW_W      = 16;
	localparam int unsigned SLICE_W    = 32;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;

	// Axis bit count fits 0..16
	localparam int unsigned CNT_W      = 5;
	localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEX_WIDTH    = 3'd0,
		REG_TEX_HEIGHT   = 3'd1,
		REG_TEX_DEPTH    = 3'd2,
		REG_PIXEL_BYTES  = 3'd3,
		REG_ROW_STRIDE   = 3'd4,
		REG_SLICE_STRIDE = 3'd5
	} reg_index_t;

	// Bits needed to address size entries, saturated at cap
	function automatic logic [CNT_W-1:0] axis_bits(input logic [SIZE_XY_W-1:0] size,
			input int cap);
		logic [SIZE_XY_W-1:0] m;
		int n;
		m = size - SIZE_XY_W'(1);
		n = 0;
		if (size > SIZE_XY_W'(1)) begin
			for (int i = 0; i < SIZE_XY_W; i++) begin
				if (m[i]) n = i + 1;
			end
		end
		if (n > cap) n = cap;
		return CNT_W'(n);
	endfunction

	function automatic int imin(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

endpackage

/* sv/tsa_coord_if.sv */
// ---------------------------------------------------------------------------
// tsa_coord_if
// Pixel coordinate channel: valid/ready with one coordinate per beat.
// ---------------------------------------------------------------------------
interface tsa_coord_if import tsa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [COORD_X_W-1:0] coord_x;
	logic [COORD_Y_W-1:0] coord_y;
	logic [COORD_Z_W-1:0] coord_z;

	modport source (output valid, output coord_x, output coord_y, output coord_z,
		input ready);
	modport sink (input valid, input coord_x, input coord_y, input coord_z,
		output ready);
endinterface

/* sv/tsa_offset_if.sv */
// ---------------------------------------------------------------------------
// tsa_offset_if
// Address result channel: valid/ready with both byte offsets per beat.
// ---------------------------------------------------------------------------
interface tsa_offset_if import tsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LIN_W-1:0] linear_offset;
	logic [SWZ_W-1:0] swizzled_offset;
	logic             in_range;

	modport source (output valid, output linear_offset, output swizzled_offset,
		output in_range, input ready);
	modport sink (input valid, input linear_offset, input swizzled_offset,
		input in_range, output ready);
endinterface

/* sv/texture_swizzle_address.sv */
// ---------------------------------------------------------------------------
// texture_swizzle_address
// Turns a 3-D pixel coordinate into its pitched linear byte offset and its
// Morton-interleaved byte offset, with an in-range flag.
// ---------------------------------------------------------------------------
// Usage:
//   coord  : sink channel, one pixel coordinate per beat.
//   offset : source channel, one result beat per coordinate, in order.
//   wr_en / wr_index / wr_data : register writes, taken on any clock with
//   wr_en high; write only while the pipeline is empty.
// An accepted coordinate passes through stages 1, 2 and 3 to its result on
// offset. Throughput is one beat per cycle while offset is not stalled:
// stage 1 scatters the coordinate bits into the interleaved index, stage 2
// holds the four products, stage 3 the final sum and is the output register.
// Each stage keeps its own valid bit and advances whenever the stage after
// it is empty or moving, so bubbles close up while the receiver stalls and
// a stalled result holds steady on offset. coord.ready drops only when all
// three stages are full and offset is stalled.
// Reset empties the pipeline and loads sizes of 1, 4 bytes per pixel and
// zero strides.
// ---------------------------------------------------------------------------
`include "texture_swizzle_address_defines.svh"

module texture_swizzle_address import tsa_pkg::*; #(
	parameter int WIDTH_BITS  = 12,
	parameter int HEIGHT_BITS = 12,
	parameter int DEPTH_BITS  = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	tsa_coord_if.sink             coord,
	tsa_offset_if.source          offset
);

	localparam int IDX_W  = WIDTH_BITS + HEIGHT_BITS + DEPTH_BITS;
	localparam int XE_W   = (WIDTH_BITS > COORD_X_W) ? WIDTH_BITS : COORD_X_W;
	localparam int YE_W   = (HEIGHT_BITS > COORD_Y_W) ? HEIGHT_BITS : COORD_Y_W;
	localparam int ZE_W   = (DEPTH_BITS > COORD_Z_W) ? DEPTH_BITS : COORD_Z_W;
	localparam int PROD_W = IDX_W + PIX_W;
	localparam int SP_W   = (PROD_W > SWZ_W) ? PROD_W : SWZ_W;
	localparam int LZ_W   = COORD_Z_W + SLICE_W;
	localparam int LY_W   = COORD_Y_W + ROW_W;
	localparam int LX_W   = COORD_X_W + PIX_W;

	// Configuration registers
	logic [SIZE_XY_W-1:0] tex_width_q, tex_height_q;
	logic [SIZE_Z_W-1:0]  tex_depth_q;
	logic [PIX_W-1:0]     pixel_bytes_q;
	logic [ROW_W-1:0]     row_stride_q;
	logic [SLICE_W-1:0]   slice_stride_q;
	logic [CNT_W-1:0]     nx_q, ny_q, nz_q;

	// Pipeline registers
	logic                 v_s1, v_s2, v_s3;
	logic [COORD_X_W-1:0] x_s1;
	logic [COORD_Y_W-1:0] y_s1;
	logic [COORD_Z_W-1:0] z_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [PIX_W-1:0]     bpp_s1;
	logic                 inr_s1, inr_s2, inr_s3;
	logic [LZ_W-1:0]      lz_s2;
	logic [LY_W-1:0]      ly_s2;
	logic [LX_W-1:0]      lx_s2;
	logic [SWZ_W-1:0]     swz_s2, swz_s3;
	logic [LIN_W-1:0]     lin_s3;

	logic                 rdy_s1, rdy_s2, rdy_s3;
	logic [IDX_W-1:0]     idx_d;
	logic [XE_W-1:0]      xe;
	logic [YE_W-1:0]      ye;
	logic [ZE_W-1:0]      ze;
	logic                 inr_d;
	logic [PIX_W-1:0]     bpp_d;
	logic [SP_W-1:0]      swz_prod;

	// Register writes; re-derive the axis bit counts with each size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q    <= SIZE_XY_W'(1);
			tex_height_q   <= SIZE_XY_W'(1);
			tex_depth_q    <= SIZE_Z_W'(1);
			pixel_bytes_q  <= PIX_W'(4);
			row_stride_q   <= '0;
			slice_stride_q <= '0;
			nx_q           <= '0;
			ny_q           <= '0;
			nz_q           <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TEX_WIDTH: begin
					tex_width_q <= wr_data[SIZE_XY_W-1:0];
					nx_q        <= axis_bits(wr_data[SIZE_XY_W-1:0], WIDTH_BITS);
				end
				REG_TEX_HEIGHT: begin
					tex_height_q <= wr_data[SIZE_XY_W-1:0];
					ny_q         <= axis_bits(wr_data[SIZE_XY_W-1:0], HEIGHT_BITS);
				end
				REG_TEX_DEPTH: begin
					tex_depth_q <= wr_data[SIZE_Z_W-1:0];
					nz_q        <= axis_bits(SIZE_XY_W'(wr_data[SIZE_Z_W-1:0]), DEPTH_BITS);
				end
				REG_PIXEL_BYTES:  pixel_bytes_q  <= wr_data[PIX_W-1:0];
				REG_ROW_STRIDE:   row_stride_q   <= wr_data[ROW_W-1:0];
				REG_SLICE_STRIDE: slice_stride_q <= wr_data[SLICE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshake: a stage takes new data when empty or when it moves on
	assign rdy_s3      = !v_s3 || offset.ready;
	assign rdy_s2      = !v_s2 || rdy_s3;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign coord.ready = rdy_s1;

	// Scatter coordinate bits round-robin x, y, z into the interleaved index
	always_comb begin
		xe    = XE_W'(coord.coord_x);
		ye    = YE_W'(coord.coord_y);
		ze    = ZE_W'(coord.coord_z);
		idx_d = '0;
		for (int k = 0; k < WIDTH_BITS; k++) begin
			if (k < int'(nx_q))
				idx_d = idx_d | (IDX_W'(xe[k])
					<< (k + imin(k, int'(ny_q)) + imin(k, int'(nz_q))));
		end
		for (int k = 0; k < HEIGHT_BITS; k++) begin
			if (k < int'(ny_q))
				idx_d = idx_d | (IDX_W'(ye[k])
					<< (imin(k + 1, int'(nx_q)) + k + imin(k, int'(nz_q))));
		end
		for (int k = 0; k < DEPTH_BITS; k++) begin
			if (k < int'(nz_q))
				idx_d = idx_d | (IDX_W'(ze[k])
					<< (imin(k + 1, int'(nx_q)) + imin(k + 1, int'(ny_q)) + k));
		end
	end

	// Range check and saturated pixel size
	assign inr_d = (SIZE_XY_W'(coord.coord_x) < tex_width_q)
		&& (SIZE_XY_W'(coord.coord_y) < tex_height_q)
		&& (SIZE_Z_W'(coord.coord_z) < tex_depth_q);
	assign bpp_d = (pixel_bytes_q > PIX_MAX) ? PIX_MAX : pixel_bytes_q;

	assign swz_prod = SP_W'(idx_s1) * SP_W'(bpp_s1);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= coord.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: capture coordinate, interleaved index and flag
	always_ff @(posedge clk) begin
		if (rdy_s1 && coord.valid) begin
			x_s1   <= coord.coord_x;
			y_s1   <= coord.coord_y;
			z_s1   <= coord.coord_z;
			idx_s1 <= idx_d;
			bpp_s1 <= bpp_d;
			inr_s1 <= inr_d;
		end
	end

	// Stage 2: one product per term
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			lz_s2  <= LZ_W'(z_s1) * LZ_W'(slice_stride_q);
			ly_s2  <= LY_W'(y_s1) * LY_W'(row_stride_q);
			lx_s2  <= LX_W'(x_s1) * LX_W'(bpp_s1);
			swz_s2 <= swz_prod[SWZ_W-1:0];
			inr_s2 <= inr_s1;
		end
	end

	// Stage 3: add the linear terms, wrap at the field width
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			lin_s3 <= LIN_W'(lz_s2) + LIN_W'(ly_s2) + LIN_W'(lx_s2);
			swz_s3 <= swz_s2;
			inr_s3 <= inr_s2;
		end
	end

	assign offset.valid           = v_s3;
	assign offset.linear_offset   = lin_s3;
	assign offset.swizzled_offset = swz_s3;
	assign offset.in_range        = inr_s3;

	// Checks
	`TSA_ASSERT_NEXT(a_s1_hold, v_s1 && !rdy_s2, v_s1 && $stable(idx_s1),
		"stage 1 lost or changed its beat during a stall")
	`TSA_ASSERT_NEXT(a_s2_move, v_s2 && rdy_s3, v_s3,
		"stage 2 beat did not reach the output register")
	`TSA_ASSERT_SAME(a_in_ready, !v_s3 || !v_s2 || !v_s1, coord.ready,
		"input stalled while the pipeline had a free stage")

endmodule
